>>> src/rre_pkg.sv
// rre_pkg: shared types and constants of the rgb row edit pipeline
// payload structs, register indexes, edit enable bit positions, row tokens
// no dependencies
package rre_pkg;

  localparam int LEN_W     = 7;
  localparam int EN_W      = 10;
  localparam int CH_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EDITS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd2;

  localparam logic [EN_W-1:0]  EDITS_RST      = 10'd0;
  localparam logic [CH_W-1:0]  MAX_COLOR_RST  = 16'd255;
  localparam logic [LEN_W-1:0] ROW_LENGTH_RST = 7'd64;
  localparam logic [LEN_W-1:0] MIN_ROW        = 7'd2;

  // edit enable bit positions
  localparam int EN_GREY     = 0;
  localparam int EN_MIRROR   = 1;
  localparam int EN_NEG_R    = 2;
  localparam int EN_ONLY_R   = 5;
  localparam int EN_BLUR     = 8;
  localparam int EN_CONTRAST = 9;

  localparam int CONTRAST_TH = 127;
  localparam int CONTRAST_HI = 255;

  localparam int ROW_BANKS   = 2;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            row_end;
  } pix_out_t;

  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
  } row_tok_t;

  typedef struct packed {
    logic [EN_W-1:0] edits;
    logic [CH_W-1:0] max_color;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic retire;
  } bk_stat_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic flush;
  } slot_t;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_DIV2 = 2'd1,
    MODE_DIV3 = 2'd2
  } blur_mode_t;

endpackage

>>> src/rre_ram.sv
// rre_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module rre_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/rre_front.sv
// rre_front: accepts pixel words, writes them into the two row banks, issues row tokens
// depends on rre_pkg
module rre_front import rre_pkg::*; #(
  parameter int MAX_ROW      = 64,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pix_in_t                      in_data,
  input  logic [LEN_W-1:0]             row_len,
  input  bk_stat_t                     bk_stat,
  output logic                         wr_en,
  output logic [$clog2(MAX_ROW):0]     wr_addr,
  output logic [3*CHANNEL_BITS-1:0]    wr_data,
  output logic                         push_valid,
  output row_tok_t                     push_data
);

  localparam int AW = $clog2(MAX_ROW);
  localparam int PW = $clog2(ROW_BANKS + 1);

  logic [LEN_W-1:0] count_r, count_nxt;
  logic             bank_r, bank_nxt;
  logic [PW-1:0]    pend_r, pend_nxt;
  logic [LEN_W-1:0] count_inc;
  logic             accept;
  logic             row_done;

  // stall only when both banks hold rows not yet read out
  assign in_ready  = (pend_r < PW'(ROW_BANKS));
  assign accept    = in_valid && in_ready;
  assign count_inc = count_r + 7'd1;
  assign row_done  = accept && (count_inc >= row_len);

  assign wr_en   = accept;
  assign wr_addr = {bank_r, count_r[AW-1:0]};
  assign wr_data = {in_data.blue_in[CHANNEL_BITS-1:0],
                    in_data.green_in[CHANNEL_BITS-1:0],
                    in_data.red_in[CHANNEL_BITS-1:0]};

  assign push_valid     = row_done;
  assign push_data.bank = bank_r;
  assign push_data.len  = row_len;

  always_comb begin
    count_nxt = count_r;
    bank_nxt  = bank_r;
    pend_nxt  = pend_r;
    if (accept) begin
      count_nxt = count_inc;
    end
    if (row_done) begin
      count_nxt = '0;
      bank_nxt  = ~bank_r;
    end
    case ({row_done, bk_stat.retire})
      2'b10:   pend_nxt = pend_r + PW'(1);
      2'b01:   pend_nxt = pend_r - PW'(1);
      default: pend_nxt = pend_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bank_r  <= 1'b0;
      pend_r  <= '0;
    end else begin
      count_r <= count_nxt;
      bank_r  <= bank_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

>>> src/rre_queue.sv
// rre_queue: short fifo of row tokens between the front and the back
// depends on rre_pkg
module rre_queue import rre_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  input  row_tok_t push_data,
  output logic     full,
  output logic     pop_valid,
  input  logic     pop_ready,
  output row_tok_t pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  row_tok_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = slot_r[rptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_ready && pop_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

>>> src/rre_back.sv
// rre_back: reads a finished row from its bank and runs the edit pipeline
// per-pixel edits, three-tap blur window, contrast and the output register; uses rre_pkg
module rre_back import rre_pkg::*; #(
  parameter int MAX_ROW      = 64,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  row_tok_t                  q_data,
  output logic                      rd_en,
  output logic [$clog2(MAX_ROW):0]  rd_addr,
  input  logic [3*CHANNEL_BITS-1:0] rd_data,
  output bk_stat_t                  bk_stat,
  output logic                      out_valid,
  input  logic                      out_ready,
  output pix_out_t                  out_data
);

  localparam int AW      = $clog2(MAX_ROW);
  localparam int CB      = CHANNEL_BITS;
  localparam int SW      = CB + 2;
  localparam int PRW     = 2 * SW;
  localparam int DIV3_SH = CB + 3;
  // reciprocal of three, exact for every sum of three channels
  localparam logic [SW-1:0] DIV3_K = SW'((1 << DIV3_SH) / 3 + 1);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_RUN  = 2'b10
  } bk_state_t;

  typedef logic [2:0][CB-1:0] pix_t;

  bk_state_t        state_r, state_nxt;
  row_tok_t         tok_r, tok_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] rd_idx;
  slot_t            slot0;
  logic             adv;
  logic             retire;

  slot_t            s1_r, s2_r, s3_r;
  pix_t             s1_pix;
  pix_t             s2_pix_r;
  logic [PRW-1:0]   s2_prod_r;
  logic [SW-1:0]    grey_sum;
  pix_t             s3_pix_r;
  pix_t             pix_edit;
  logic [CB-1:0]    grey_val;
  logic [CB-1:0]    mc;

  pix_t             prev_r, prev_nxt;
  pix_t             cur_r, cur_nxt;
  logic             have_r, have_nxt;
  logic             cur_first_r, cur_first_nxt;
  logic             s4_emit;
  logic             s4_last;
  blur_mode_t       s4_mode;
  logic [2:0][SW-1:0] s4_sum;

  logic             s4_valid_r, s4_last_r;
  blur_mode_t       s4_mode_r;
  logic [2:0][SW-1:0] s4_sum_r;

  logic             s5_valid_r, s5_last_r;
  blur_mode_t       s5_mode_r;
  logic [2:0][SW-1:0]  s5_sum_r;
  logic [2:0][PRW-1:0] s5_prod_r;

  pix_t             fin;
  logic             out_valid_r;
  pix_out_t         out_data_r;

  // whole pipeline moves together, held while the output word waits
  assign adv = !out_valid_r || out_ready;

  // row sequencer: one read a cycle while the pipeline advances, then a flush slot that closes the blur window
  always_comb begin
    state_nxt = state_r;
    tok_nxt   = tok_r;
    idx_nxt   = idx_r;
    q_ready   = 1'b0;
    rd_en     = 1'b0;
    retire    = 1'b0;
    slot0     = '0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_ready   = 1'b1;
          tok_nxt   = q_data;
          idx_nxt   = '0;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (adv) begin
          if (idx_r < tok_r.len) begin
            rd_en       = 1'b1;
            slot0.valid = 1'b1;
            slot0.first = (idx_r == '0);
            idx_nxt     = idx_r + 7'd1;
          end else begin
            slot0.valid = 1'b1;
            slot0.flush = 1'b1;
            retire      = 1'b1;
            state_nxt   = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign rd_idx  = cfg.edits[EN_MIRROR] ? (tok_r.len - 7'd1 - idx_r) : idx_r;
  assign rd_addr = {tok_r.bank, rd_idx[AW-1:0]};

  assign bk_stat.busy   = (state_r == BK_RUN);
  assign bk_stat.retire = retire;

  // per-pixel edits
  assign s1_pix   = rd_data;
  assign grey_sum = {2'b00, s1_pix[0]} + {2'b00, s1_pix[1]} + {2'b00, s1_pix[2]};
  assign grey_val = s2_prod_r[DIV3_SH +: CB];
  assign mc       = cfg.max_color[CB-1:0];

  always_comb begin
    pix_t g;
    g = s2_pix_r;
    if (cfg.edits[EN_GREY]) begin
      g = {grey_val, grey_val, grey_val};
    end
    for (int c = 0; c < 3; c++) begin
      if (cfg.edits[EN_NEG_R + c]) begin
        g[c] = (g[c] > mc) ? '0 : mc - g[c];
      end
    end
    for (int k = 0; k < 3; k++) begin
      pix_edit[k] = g[k];
      for (int c = 0; c < 3; c++) begin
        if (c != k && cfg.edits[EN_ONLY_R + c]) begin
          pix_edit[k] = '0;
        end
      end
    end
  end

  // blur window: a pixel leaves once its right neighbour or the flush slot arrives
  always_comb begin
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    have_nxt      = have_r;
    cur_first_nxt = cur_first_r;
    s4_emit       = 1'b0;
    s4_last       = 1'b0;
    s4_mode       = MODE_PASS;
    s4_sum        = '0;
    if (s3_r.valid) begin
      s4_emit = have_r;
      if (s3_r.flush) begin
        s4_last  = 1'b1;
        have_nxt = 1'b0;
        for (int c = 0; c < 3; c++) begin
          s4_sum[c] = {2'b00, prev_r[c]} + {2'b00, cur_r[c]};
        end
        s4_mode = MODE_DIV2;
      end else begin
        for (int c = 0; c < 3; c++) begin
          if (cur_first_r) begin
            s4_sum[c] = {2'b00, cur_r[c]} + {2'b00, s3_pix_r[c]};
          end else begin
            s4_sum[c] = {2'b00, prev_r[c]} + {2'b00, cur_r[c]} + {2'b00, s3_pix_r[c]};
          end
        end
        s4_mode       = cur_first_r ? MODE_DIV2 : MODE_DIV3;
        prev_nxt      = cur_r;
        cur_nxt       = s3_pix_r;
        have_nxt      = 1'b1;
        cur_first_nxt = s3_r.first;
      end
      if (!cfg.edits[EN_BLUR]) begin
        s4_mode = MODE_PASS;
        for (int c = 0; c < 3; c++) begin
          s4_sum[c] = {2'b00, cur_r[c]};
        end
      end
    end
  end

  // final divide and contrast
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (s5_mode_r)
        MODE_DIV3: fin[c] = s5_prod_r[c][DIV3_SH +: CB];
        MODE_DIV2: fin[c] = s5_sum_r[c][CB:1];
        default:   fin[c] = s5_sum_r[c][CB-1:0];
      endcase
      if (cfg.edits[EN_CONTRAST]) begin
        fin[c] = (fin[c] > CB'(CONTRAST_TH)) ? CB'(CONTRAST_HI) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      s1_r        <= '0;
      s2_r        <= '0;
      s3_r        <= '0;
      have_r      <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        s1_r        <= slot0;
        s2_r        <= s1_r;
        s3_r        <= s2_r;
        have_r      <= have_nxt;
        s4_valid_r  <= s4_emit;
        s5_valid_r  <= s4_valid_r;
        out_valid_r <= s5_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    idx_r <= idx_nxt;
    if (adv) begin
      s2_pix_r    <= s1_pix;
      s2_prod_r   <= {{SW{1'b0}}, grey_sum} * {{SW{1'b0}}, DIV3_K};
      s3_pix_r    <= pix_edit;
      prev_r      <= prev_nxt;
      cur_r       <= cur_nxt;
      cur_first_r <= cur_first_nxt;
      s4_last_r   <= s4_last;
      s4_mode_r   <= s4_mode;
      s4_sum_r    <= s4_sum;
      s5_last_r   <= s4_last_r;
      s5_mode_r   <= s4_mode_r;
      s5_sum_r    <= s4_sum_r;
      for (int c = 0; c < 3; c++) begin
        s5_prod_r[c] <= {{SW{1'b0}}, s4_sum_r[c]} * {{SW{1'b0}}, DIV3_K};
      end
      out_data_r.red_out   <= CH_W'(fin[0]);
      out_data_r.green_out <= CH_W'(fin[1]);
      out_data_r.blue_out  <= CH_W'(fin[2]);
      out_data_r.row_end   <= s5_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/rgb_row_edit_pipeline.sv
// rgb_row_edit_pipeline: row buffered rgb pixel editor, top level
// a row is read after its last pixel is taken: ram read, s2, s3, s4, s5, output regs
// input: one pixel a cycle while in_ready is high; each row read ends in a flush slot
// two row banks in one ram: input stalls only while both banks hold unread rows
// reset: control state and registers go to defaults; the row store is not cleared
module rgb_row_edit_pipeline import rre_pkg::*; #(
  parameter int MAX_ROW      = 64,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pix_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pix_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_ROW);
  localparam int DW = 3 * CHANNEL_BITS;
  localparam logic [CH_W-1:0] CH_MAX = CH_W'((1 << CHANNEL_BITS) - 1);

  logic [EN_W-1:0]  edits_r;
  logic [CH_W-1:0]  max_color_r;
  logic [LEN_W-1:0] row_length_r;
  logic [LEN_W-1:0] row_len;
  cfg_t             cfg;

  logic             wr_en;
  logic [AW:0]      wr_addr;
  logic [DW-1:0]    wr_data;
  logic             rd_en;
  logic [AW:0]      rd_addr;
  logic [DW-1:0]    rd_data;

  logic             q_push;
  row_tok_t         q_push_data;
  logic             q_full;
  logic             q_pop_valid;
  logic             q_pop_ready;
  row_tok_t         q_pop_data;
  bk_stat_t         bk_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edits_r      <= EDITS_RST;
      max_color_r  <= MAX_COLOR_RST;
      row_length_r <= ROW_LENGTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_EDITS:      edits_r      <= cfg_data[EN_W-1:0];
        CFG_MAX_COLOR:  max_color_r  <= cfg_data[CH_W-1:0];
        CFG_ROW_LENGTH: row_length_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp row length into the supported range
  always_comb begin
    row_len = row_length_r;
    if (row_length_r < MIN_ROW) begin
      row_len = MIN_ROW;
    end else if (row_length_r > LEN_W'(MAX_ROW)) begin
      row_len = LEN_W'(MAX_ROW);
    end
  end

  assign cfg.edits     = edits_r;
  assign cfg.max_color = (max_color_r > CH_MAX) ? CH_MAX : max_color_r;

  rre_front #(
    .MAX_ROW      (MAX_ROW),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .row_len    (row_len),
    .bk_stat    (bk_stat),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .push_valid (q_push),
    .push_data  (q_push_data)
  );

  // each bank spans a power of two so the bank bit sits above the pixel index
  rre_ram #(
    .WIDTH (DW),
    .DEPTH (ROW_BANKS << AW)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rre_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  rre_back #(
    .MAX_ROW      (MAX_ROW),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_pop_valid),
    .q_ready   (q_pop_ready),
    .q_data    (q_pop_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .bk_stat   (bk_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a row token never arrives at a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("row token pushed into full queue");

  // input stalls only while a row waits in the queue or is being read out
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (q_pop_valid || bk_stat.busy))
    else $error("input stalled with no row pending");

  // a bank is released only by a row that was being read out
  a_retire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.retire |-> bk_stat.busy)
    else $error("bank released while back idle");

  // no result word right after reset
  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid after reset");

endmodule
